// ===== hw/rtl/vector_range_allocator_macros.svh =====
// assertion macros used by the checker file
`ifndef VECTOR_RANGE_ALLOCATOR_MACROS_SVH
`define VECTOR_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while rst_dis is high
`define VRA_ASSERT_NOW(label, clk, rst_dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while rst_dis is high
`define VRA_ASSERT_NEXT(label, clk, rst_dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/vra_pkg.sv =====
// shared constants and types of the vector range allocator
`default_nettype none

package vra_pkg;

  localparam int VECTORS_DEF        = 256;
  localparam int FIRST_SEARCHED_DEF = 32;

  localparam int FIELD_W     = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic FUNC_MARK   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // mark request from the input channel to the used map
  typedef struct packed {
    logic               en;
    logic [FIELD_W-1:0] vector;
  } mark_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vra_used_map.sv =====
// generic ram with one write port and one registered read port, holds the used-bit map
`default_nettype none

module vra_used_map #(
  parameter int WIDTH   = 1,
  parameter int DEPTH   = vra_pkg::VECTORS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vector_range_allocator.sv =====
// top level: first-fit allocator of interrupt vector ranges over a used-bit map
//
// input channel in_*: one transfer is one command. in_tuser selects the
//   function: mark (set one vector's used bit) or search (find a free range).
// output channel out_*: one transfer per search, none per mark.
// a mark goes to the map on its transfer; in_tready stays high and the next
//   command may follow at once.
// a search runs on one shared adder under a small sequencer and reads the map
//   one bit per cycle from a ram with registered read: per candidate start a
//   bound check, a fetch of the first vector, a scan of the run and a step
//   to the next start.
// a count that does not fit at the first start is refused after that bound
//   check.
// in_tready is low while a search runs.
// the result sits in an output register; if the receiver stalls, a second
//   finished search waits with in_tready low until that register frees.
// reset (rst_n low, synchronous) drops any pending result; the map is then
//   cleared by a pass over all VECTORS entries, one vector per cycle, in_tready low.
`default_nettype none

module vector_range_allocator #(
  parameter int VECTORS        = vra_pkg::VECTORS_DEF,
  parameter int FIRST_SEARCHED = vra_pkg::FIRST_SEARCHED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // vector [7:0], count [15:8], min_run [23:16], aligned [24], zero [31:25]
  input  logic [vra_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found [0], start_res [8:1], len [16:9], zero [23:17]
  output logic [vra_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(VECTORS);
  localparam int SUM_W = $clog2(VECTORS + 256);
  localparam int FW    = vra_pkg::FIELD_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;  // bound check of the candidate start
  localparam logic [2:0] S_SCAN  = 3'd2;  // one vector per cycle
  localparam logic [2:0] S_STEP  = 3'd3;  // advance to the next start
  localparam logic [2:0] S_DONE  = 3'd4;  // hand result to output register
  localparam logic [2:0] S_CLEAR = 3'd5;  // clearing pass after reset
  localparam logic [2:0] S_FETCH = 3'd6;  // read the first vector of the start

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [FW-1:0]    run_r, run_nxt;
  logic [FW-1:0]    count_r, min_r;
  logic             aligned_r;
  logic             hit_r, hit_nxt;

  logic             out_valid_r;
  logic             out_found_r;
  logic [FW-1:0]    out_start_r, out_len_r;

  logic             in_xfer, out_xfer, load_out;
  logic [SUM_W-1:0] add_b, sum;
  logic             add_cin;
  logic             used_bit;
  vra_pkg::mark_t   mark;
  logic             mark_ok;
  logic             clearing;
  logic             wr_en, wr_data;
  logic [IDX_W-1:0] wr_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // mark goes straight to the map on the transfer
  assign mark.en     = in_xfer && (in_tuser == vra_pkg::FUNC_MARK);
  assign mark.vector = in_tdata[7:0];

  // marks beyond the map are dropped
  assign mark_ok = ({24'd0, mark.vector} < VECTORS);

  // write port: the clearing pass writes zeros, a mark writes a one
  assign clearing = (state_r == S_CLEAR);
  assign wr_en    = clearing || (mark.en && mark_ok);
  assign wr_addr  = clearing ? start_r : IDX_W'(mark.vector);
  assign wr_data  = !clearing;

  // the shared adder: start plus count, run, step or one depending on the state;
  // while scanning the carry-in fetches the vector after the one checked
  always_comb begin
    unique case (state_r)
      S_CLEAR: add_b = SUM_W'(1);
      S_HEAD:  add_b = SUM_W'(count_r);
      S_SCAN:  add_b = SUM_W'(run_r);
      S_STEP:  add_b = aligned_r ? SUM_W'(count_r) : SUM_W'(1);
      default: add_b = '0;
    endcase
  end

  assign add_cin = (state_r == S_SCAN);
  assign sum     = SUM_W'(start_r) + add_b + SUM_W'(add_cin);

  vra_used_map #(
    .WIDTH (1),
    .DEPTH (VECTORS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (sum[IDX_W-1:0]),
    .rd_data (used_bit)
  );

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      S_CLEAR: begin
        start_nxt = sum[IDX_W-1:0];
        if (start_r == IDX_W'(VECTORS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && (in_tuser == vra_pkg::FUNC_SEARCH)) begin
          start_nxt = IDX_W'(FIRST_SEARCHED);
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        run_nxt = '0;
        if (sum < SUM_W'(VECTORS)) begin
          state_nxt = S_FETCH;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_FETCH: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // used_bit is the map bit of start + run, read in the cycle before
        if (run_r == count_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (used_bit) begin
          if (run_r >= min_r) begin
            hit_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end else begin
          run_nxt = run_r + FW'(1);
        end
      end
      S_STEP: begin
        // the bound check keeps start + count below the map size
        start_nxt = sum[IDX_W-1:0];
        state_nxt = S_HEAD;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    run_r   <= run_nxt;
    hit_r   <= hit_nxt;
    if (in_xfer) begin
      count_r   <= in_tdata[15:8];
      min_r     <= in_tdata[23:16];
      aligned_r <= in_tdata[24];
    end
    if (load_out) begin
      out_found_r <= hit_r;
      out_start_r <= hit_r ? FW'(start_r) : '0;
      out_len_r   <= hit_r ? run_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_len_r, out_start_r, out_found_r};

endmodule

`default_nettype wire

// ===== hw/rtl/vra_checker.sv =====
// port-level checker of the vector range allocator, bound to the top level
`default_nettype none

`include "vector_range_allocator_macros.svh"

module vra_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [vra_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `VRA_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))

  // a miss carries zero start and length
  `VRA_ASSERT_NOW(a_miss_zero, clk, !rst_n, out_tvalid && !out_tdata[0],
    out_tdata[16:1] == 16'd0)

  // a search transfer makes the block busy in the next cycle
  `VRA_ASSERT_NEXT(a_search_busy, clk, !rst_n,
    in_tvalid && in_tready && (in_tuser == vra_pkg::FUNC_SEARCH), !in_tready)

  // reset drops any pending result
  `VRA_ASSERT_NEXT(a_reset_clear, clk, 1'b0, !rst_n, !out_tvalid)

endmodule

bind vector_range_allocator vra_checker u_vra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench of the vector range allocator: directed and random marks and searches
module testbench;

  localparam int MAP_SIZE     = vra_pkg::VECTORS_DEF;
  localparam int FIRST_START  = vra_pkg::FIRST_SEARCHED_DEF;
  localparam int RANDOM_ITEMS = 1730;
  localparam int DRAIN_EVERY  = 400;
  localparam int IDLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED  = 20;
  localparam int IN_W         = vra_pkg::IN_TDATA_W;
  localparam int OUT_W        = vra_pkg::OUT_TDATA_W;

  localparam logic CMD_MARK   = vra_pkg::FUNC_MARK;
  localparam logic CMD_SEARCH = vra_pkg::FUNC_SEARCH;

  // one search answer, as the block should return it
  typedef struct {
    bit       found;
    bit [7:0] start_res;
    bit [7:0] len;
  } grant_t;

  // keeps its own used map and the answers still owed by the block
  class alloc_scoreboard;
    bit     used_map [MAP_SIZE];
    grant_t grants_due [$];
    int     mismatches;
    int     marks;
    int     searches;
    int     granted;
    int     refused;

    // first-fit scan over candidate starts, as the block should do it
    function grant_t first_fit(bit [7:0] count, bit [7:0] min_run, bit aligned);
      grant_t g;
      int     start;
      int     run;
      bit     done;
      g.found     = 1'b0;
      g.start_res = '0;
      g.len       = '0;
      start       = FIRST_START;
      done        = 1'b0;
      while (!done && start + count < MAP_SIZE) begin
        run = 0;
        while (run < count && !used_map[start + run]) run++;
        // full run, or a used vector met after enough free ones
        if (run == count || run >= min_run) begin
          g.found     = 1'b1;
          g.start_res = start[7:0];
          g.len       = run[7:0];
          done        = 1'b1;
        end else begin
          start += aligned ? count : 1;
        end
      end
      return g;
    endfunction

    function void note_command(bit func, bit [7:0] vector, bit [7:0] count,
                               bit [7:0] min_run, bit aligned);
      if (func == CMD_MARK) begin
        if (vector < MAP_SIZE) used_map[vector] = 1'b1;
        marks++;
      end else begin
        grants_due.push_back(first_fit(count, min_run, aligned));
        searches++;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task check_grant(logic [OUT_W-1:0] tdata);
      grant_t     want;
      logic       found;
      logic [7:0] start_res;
      logic [7:0] len;
      found     = tdata[0];
      start_res = tdata[8:1];
      len       = tdata[16:9];
      if (grants_due.size() == 0) begin
        report($sformatf("result with no search pending: tdata %h", tdata));
      end else begin
        want = grants_due.pop_front();
        if (found !== want.found)
          report($sformatf("found %b, want %b", found, want.found));
        if (start_res !== want.start_res)
          report($sformatf("start_res %0d, want %0d", start_res, want.start_res));
        if (len !== want.len)
          report($sformatf("len %0d, want %0d", len, want.len));
        if (want.found) granted++;
        else refused++;
      end
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tuser   = CMD_MARK;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  alloc_scoreboard sb;
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;

  vector_range_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // one command transfer; the optional gap comes before tvalid rises
  task send_cmd(input bit func, input bit [7:0] vector, input bit [7:0] count,
                input bit [7:0] min_run, input bit aligned);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'b0, aligned, min_run, count, vector};
    do @(posedge clk); while (!in_tready);
    sb.note_command(func, vector, count, min_run, aligned);
  endtask

  // hold off the sender until every pending search has answered
  task drain_searches();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.grants_due.size() != 0);
  endtask

  // receiver: random stall before each result, with stall-free stretches
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 31) == 0) receiver_steady = !receiver_steady;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_grant(out_tdata);
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled = 0;
      else stalled++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit       func;
    bit [7:0] vector;
    bit [7:0] count;
    bit [7:0] min_run;
    bit       aligned;
    int       pick;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the empty map
    send_cmd(CMD_SEARCH, 8'd0,   8'd0,   8'd0,   1'b0); // zero count: first start at once
    send_cmd(CMD_SEARCH, 8'd255, 8'd223, 8'd255, 1'b1); // widest range that still fits
    send_cmd(CMD_SEARCH, 8'd0,   8'd224, 8'd0,   1'b0); // count too large, no start tried
    send_cmd(CMD_SEARCH, 8'd0,   8'd255, 8'd255, 1'b1);
    send_cmd(CMD_MARK,   8'd0,   8'd0,   8'd0,   1'b0); // outside the searched window
    send_cmd(CMD_MARK,   8'd255, 8'd255, 8'd255, 1'b1);
    send_cmd(CMD_MARK,   8'd32,  8'd0,   8'd0,   1'b0);
    send_cmd(CMD_MARK,   8'd32,  8'd0,   8'd0,   1'b0); // marking again changes nothing
    send_cmd(CMD_SEARCH, 8'd0,   8'd4,   8'd0,   1'b0); // zero min_run at a used start
    send_cmd(CMD_SEARCH, 8'd0,   8'd4,   8'd4,   1'b0);
    send_cmd(CMD_SEARCH, 8'd0,   8'd8,   8'd8,   1'b1); // aligned steps over the used start
    send_cmd(CMD_MARK,   8'd36,  8'd0,   8'd0,   1'b0);
    send_cmd(CMD_SEARCH, 8'd0,   8'd8,   8'd3,   1'b0); // partial run before a used vector
    send_cmd(CMD_SEARCH, 8'd0,   8'd200, 8'd255, 1'b0);
    send_cmd(CMD_SEARCH, 8'd0,   8'd222, 8'd255, 1'b0); // every start blocked
    send_cmd(CMD_SEARCH, 8'd0,   8'd0,   8'd255, 1'b1); // zero count on a used start
    send_cmd(CMD_MARK,   8'd37,  8'd255, 8'd255, 1'b1);
    send_cmd(CMD_SEARCH, 8'd255, 8'd1,   8'd1,   1'b1);
    drain_searches();

    // random part: mostly searches, marks slowly fill the map
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 31) == 0) sender_steady = !sender_steady;
      if (i > 0 && i % DRAIN_EVERY == 0) drain_searches();
      func   = ($urandom_range(0, 9) == 0) ? CMD_MARK : CMD_SEARCH;
      vector = 8'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 60)      count = 8'($urandom_range(0, 15));
      else if (pick < 85) count = 8'($urandom_range(16, 63));
      else if (pick < 95) count = 8'($urandom_range(64, 223));
      else                count = 8'($urandom_range(224, 255));
      pick = $urandom_range(0, 3);
      if (pick < 2)       min_run = 8'($urandom_range(0, count));
      else if (pick == 2) min_run = 8'($urandom_range(0, 3));
      else                min_run = 8'($urandom);
      aligned = 1'($urandom);
      send_cmd(func, vector, count, min_run, aligned);
    end
    in_tvalid <= 1'b0;

    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d marks and %0d searches", sb.marks, sb.searches);
    $display("searches answered: %0d ranges granted, %0d refused, %0d mismatches",
             sb.granted, sb.refused, sb.mismatches);
    if (sb.mismatches == 0 && sb.grants_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
